// File: rtl/npc_pkg.sv
// Shared types, constants and a helper function for the nearest palette colour search.
package npc_pkg;

	// Field widths of the item and the result.
	localparam int COLOR_W = 24;
	localparam int CHAN_W  = 8;
	localparam int INDEX_W = 8;
	localparam int SIZE_W  = 9;

	// Squared distance over three channels never exceeds 3 * 255 * 255.
	localparam int SQ_W   = 2 * CHAN_W;
	localparam int DIST_W = 18;
	localparam logic [DIST_W-1:0] DIST_BOUND = 18'd195075;

	// Default palette depth.
	localparam int PALETTE_DEPTH_DEF = 256;

	// Item modes.
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// Control states of the search sequencer.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} npc_state_t;

	// Square of the absolute difference of two channel values.
	function automatic logic [SQ_W-1:0] chan_sq(input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b);
		logic [CHAN_W-1:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return {{CHAN_W{1'b0}}, d} * {{CHAN_W{1'b0}}, d};
	endfunction

endpackage

// File: rtl/npc_best.sv
// Distance stage and running best-candidate tracker for the palette search.
module npc_best
	import npc_pkg::*;
#(
	parameter int AW = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               cand_valid,
	input  logic [AW-1:0]      cand_idx,
	input  logic [COLOR_W-1:0] cand_color,
	input  logic [COLOR_W-1:0] query_color,
	output logic [AW-1:0]      best_idx,
	output logic               busy
);

	logic [SQ_W-1:0]   r_sq_s2;
	logic [SQ_W-1:0]   g_sq_s2;
	logic [SQ_W-1:0]   b_sq_s2;
	logic [AW-1:0]     idx_s2;
	logic              vld_s2;
	logic [DIST_W-1:0] dist_sum;
	logic [DIST_W-1:0] best_dist_q;
	logic [AW-1:0]     best_idx_q;

	// Valid flag of the squaring stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= cand_valid;
		end
	end

	// Per-channel squared differences, one register stage after the memory read.
	always_ff @(posedge clk) begin
		r_sq_s2 <= chan_sq(cand_color[7:0], query_color[7:0]);
		g_sq_s2 <= chan_sq(cand_color[15:8], query_color[15:8]);
		b_sq_s2 <= chan_sq(cand_color[23:16], query_color[23:16]);
		idx_s2  <= cand_idx;
	end

	// Sum of the three squares.
	assign dist_sum = DIST_W'(r_sq_s2) + DIST_W'(g_sq_s2) + DIST_W'(b_sq_s2);

	// An entry with a strictly smaller distance replaces the best so far, so ties keep the earlier entry.
	always_ff @(posedge clk) begin
		if (start) begin
			best_dist_q <= DIST_BOUND;
			best_idx_q  <= '0;
		end else if (vld_s2 && (dist_sum < best_dist_q)) begin
			best_dist_q <= dist_sum;
			best_idx_q  <= idx_s2;
		end
	end

	assign best_idx = best_idx_q;
	assign busy     = vld_s2;

endmodule

// File: rtl/nearest_palette_color_core.sv
// Nearest palette colour search: palette memory, scan sequencer and result register.
// A load item writes its palette slot at the accepting edge.
// A query item scans n = min(palette_size, PALETTE_DEPTH) entries one read at a time
// through the single read port of the palette memory; the input stalls from acceptance
// until the result is loaded and while the result waits.
// Reset clears the sequencer, the result valid and palette_size; palette contents are kept.
module nearest_palette_color_core
	import npc_pkg::*;
#(
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic [INDEX_W-1:0] entry_index,
	input  logic [COLOR_W-1:0] color,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [INDEX_W-1:0] nearest_index,
	input  logic               cfg_wen,
	input  logic [SIZE_W-1:0]  cfg_wdata
);

	localparam int AW = $clog2(PALETTE_DEPTH);
	localparam int NW = AW + 1;
	localparam int CW = AW + SIZE_W;

	npc_state_t         state_q;
	npc_state_t         state_d;
	logic [SIZE_W-1:0]  palette_size_q;
	logic [COLOR_W-1:0] query_q;
	logic [NW-1:0]      n_q;
	logic [NW-1:0]      cnt_q;
	logic               rd_vld_s1;
	logic [AW-1:0]      rd_idx_s1;
	logic [COLOR_W-1:0] rd_data_s1;
	logic [COLOR_W-1:0] mem [PALETTE_DEPTH];
	logic               start;
	logic               issue;
	logic               out_load;
	logic               mem_we;
	logic [CW-1:0]      slot_ext;
	logic [CW-1:0]      size_ext;
	logic [NW-1:0]      n_next;
	logic [AW-1:0]      best_idx;
	logic [CW-1:0]      best_ext;
	logic               cand_busy;
	logic               out_valid_q;
	logic [INDEX_W-1:0] nearest_index_q;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_size_q <= '0;
		end else if (cfg_wen) begin
			palette_size_q <= cfg_wdata;
		end
	end

	// Slot range check and search length clamped to the palette depth.
	assign slot_ext = CW'(entry_index);
	assign size_ext = CW'(palette_size_q);
	assign n_next   = (size_ext > CW'(PALETTE_DEPTH)) ? NW'(PALETTE_DEPTH) : NW'(size_ext);
	assign mem_we   = in_valid && !in_stall && (mode == MODE_LOAD) &&
		(slot_ext < CW'(PALETTE_DEPTH));

	// Palette memory: one write port for loads, one registered read port for the scan.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[slot_ext[AW-1:0]] <= color;
		end
		if (issue) begin
			rd_data_s1 <= mem[cnt_q[AW-1:0]];
		end
	end

	// Read tracking: index and valid travel with the memory data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q[AW-1:0];
	end

	// Query colour and search length, captured when a query item is accepted.
	always_ff @(posedge clk) begin
		if (start) begin
			query_q <= color;
			n_q     <= n_next;
		end
	end

	// Scan address counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= '0;
		end else if (issue) begin
			cnt_q <= cnt_q + NW'(1);
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control: scan until every read has drained, then hand over the result.
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		start    = 1'b0;
		issue    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && (mode == MODE_QUERY)) begin
					start   = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				issue = (cnt_q != n_q);
				if (!issue && !rd_vld_s1 && !cand_busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				out_load = !out_valid_q || !out_stall;
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Distance computation and best-candidate tracking.
	npc_best #(
		.AW (AW)
	) u_best (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.cand_valid  (rd_vld_s1),
		.cand_idx    (rd_idx_s1),
		.cand_color  (rd_data_s1),
		.query_color (query_q),
		.best_idx    (best_idx),
		.busy        (cand_busy)
	);

	assign best_ext = CW'(best_idx);

	// Result register: holds the item until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			nearest_index_q <= best_ext[INDEX_W-1:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign nearest_index = nearest_index_q;

`ifndef SYNTH
	// The scan never reads past the clamped search length.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (cnt_q <= n_q))
		else $error("scan counter ran past the search length");

	// No read is in flight once the sequencer is back to idle.
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!rd_vld_s1 && !cand_busy))
		else $error("palette read still in flight while idle");

	// An accepted query starts a scan in the next cycle.
	a_query_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (mode == MODE_QUERY)) |=> (state_q == ST_SCAN))
		else $error("accepted query did not start a scan");

	// A new result appears only after a finished scan.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised without a finished scan");
`endif

endmodule
